// File: hw/rtl/crc8_command_frame_parser_assert.svh
// Assertion helpers used by the checker module of this block.
`ifndef CRC8_COMMAND_FRAME_PARSER_ASSERT_SVH
`define CRC8_COMMAND_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define CRCFP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define CRCFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication that is also checked around reset.
`define CRCFP_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/crcfp_pkg.sv
`timescale 1ns / 1ps

package crcfp_pkg;

   // Default frame length limit before an open frame is dropped
   localparam int MAX_FRAME_BYTES_DEF = 8;

   // Frame positions that are stored (bytes 0 to 6); only bytes 0 to 4 are read back
   localparam int STORE_BYTES = 7;
   localparam int STORE_IDX_W = 3;

   localparam logic [7:0] CRC_POLY        = 8'h31;
   localparam logic [7:0] HDR_SPEED       = 8'hEE;
   localparam logic [7:0] HDR_DIR         = 8'hCC;
   localparam logic [7:0] MARK_02         = 8'h02;
   localparam logic [7:0] TAIL_SPEED      = 8'hFF;
   localparam logic [7:0] TAIL_DIR        = 8'h33;
   localparam logic [7:0] SPEED_CMD_RESET = 8'h07;

   // Result kinds
   localparam logic KIND_SPEED = 1'b0;
   localparam logic KIND_DIR   = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
   } result_type;

   // One byte of CRC-8, polynomial 0x31, MSB first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/crcfp_parser.sv
`timescale 1ns / 1ps

module crcfp_parser
   import crcfp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       byte_valid,
   input  logic [7:0] byte_data,
   output logic       res_valid,
   output result_type res_data
);

   localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

   logic [7:0]    speed_cmd_ff;
   logic          in_frame_ff, in_frame_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    crc_ff, crc_in;
   logic          match4_ff, match5_ff;
   logic [7:0]    bytes_ff [STORE_BYTES];

   logic          start, take;
   logic [CW-1:0] cnt, new_cnt;
   logic          speed_close, dir_close, drop;

   // Open a frame on a header byte while idle
   assign start = !in_frame_ff && ((byte_data == HDR_SPEED) || (byte_data == HDR_DIR));
   assign take  = byte_valid && (in_frame_ff || start);
   assign cnt   = start ? '0 : count_ff;
   assign new_cnt = cnt + CW'(1);

   // Close checks on the byte that completes six or seven bytes
   assign speed_close = (new_cnt == CW'(6)) && (bytes_ff[0] == HDR_SPEED)
                        && (bytes_ff[1] == MARK_02) && (byte_data == TAIL_SPEED);
   assign dir_close   = (new_cnt == CW'(7)) && (bytes_ff[0] == HDR_DIR)
                        && (bytes_ff[3] == MARK_02) && (byte_data == TAIL_DIR);
   assign drop        = (new_cnt == CW'(MAX_FRAME_BYTES));

   // Running CRC over the frame bytes
   assign crc_in = crc8_byte(start ? 8'h00 : crc_ff, byte_data);

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      if (take) begin
         count_in    = new_cnt;
         in_frame_in = !(speed_close || dir_close || drop);
      end
   end

   // Build the result of this byte
   always_comb begin
      res_valid      = 1'b0;
      res_data.kind  = KIND_SPEED;
      res_data.value = bytes_ff[3];
      if (take && speed_close) begin
         res_valid = (bytes_ff[2] == speed_cmd_ff) && match4_ff;
      end else if (take && dir_close) begin
         res_valid      = match5_ff;
         res_data.kind  = KIND_DIR;
         res_data.value = bytes_ff[4];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_cmd_ff <= SPEED_CMD_RESET;
         in_frame_ff  <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            speed_cmd_ff <= csr_wr_data;
         end
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
      end
   end

   // Frame bytes, CRC and check flags
   always_ff @(posedge clock) begin
      if (take) begin
         crc_ff <= crc_in;
         if (cnt < CW'(STORE_BYTES)) begin
            bytes_ff[cnt[STORE_IDX_W-1:0]] <= byte_data;
         end
         if (cnt == CW'(4)) begin
            match4_ff <= (crc_ff == byte_data);
         end
         if (cnt == CW'(5)) begin
            match5_ff <= (crc_ff == byte_data);
         end
      end
   end

endmodule

// File: hw/rtl/crcfp_outq.sv
`timescale 1ns / 1ps

module crcfp_outq
   import crcfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic [1:0] count_ff;
   logic       wr_ptr_ff, rd_ptr_ff;
   result_type slot_ff [2];
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign space     = (count_ff != 2'd2);
   assign out_data  = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // Hold the queued results
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/crc8_command_frame_parser.sv
`timescale 1ns / 1ps

// Framed command parser: takes one received byte per transfer and can accept a
// byte every clock cycle while req_tready is high; the byte that closes a valid
// frame queues its result for the rsp side. A running CRC-8 (polynomial 0x31) is
// updated as each byte is taken, so closing a frame needs no extra CRC pass. A
// two-entry result queue separates the sides: req_tready drops only while two
// results wait unread. A speed frame reads EE 02 cmd val crc FF, with cmd equal
// to the csr register (reset 0x07); a direction frame reads CC x x 02 val crc 33.
// A frame that reaches MAX_FRAME_BYTES bytes without closing is dropped.
module crc8_command_frame_parser
   import crcfp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] result_value
   output logic       rsp_tuser    // [0] result_kind
);

   logic       space;
   logic       res_valid;
   result_type res_data, out_data;

   assign req_tready = space;

   crcfp_parser #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .byte_valid (req_tvalid && space),
      .byte_data  (req_tdata),
      .res_valid  (res_valid),
      .res_data   (res_data)
   );

   crcfp_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push     (res_valid),
      .push_data(res_data),
      .space    (space),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (out_data)
   );

   assign rsp_tdata = out_data.value;
   assign rsp_tuser = out_data.kind;

endmodule

// File: hw/rtl/crcfp_checker.sv
`timescale 1ns / 1ps

`include "crc8_command_frame_parser_assert.svh"

module crcfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser
);

   // A stalled result stays offered
   `CRCFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid, "rsp dropped while stalled")

   // A stalled result keeps its kind and value
   `CRCFP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready,
      $stable({rsp_tuser, rsp_tdata}), "rsp changed while stalled")

   // Reset leaves the queue empty and the input open
   `CRCFP_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset),
      req_tready && !rsp_tvalid, "queue not empty after reset")

   // Input stalls only while results wait
   `CRCFP_ASSERT_IMPLY(a_stall_cause, clock, reset, !req_tready,
      rsp_tvalid, "input stalled with no result pending")

   // A result appears only after an input transfer
   `CRCFP_ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_tvalid),
      $past(req_tvalid && req_tready), "result without input transfer")

endmodule

bind crc8_command_frame_parser crcfp_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
